[design/dpdr_pkg.sv]
package dpdr_pkg;

    // field widths
    localparam int DELAY_W  = 16;
    localparam int SAMPLE_W = 8;
    localparam int ACTION_W = 2;
    localparam int PERIOD_W = 8;
    localparam int CFG_ADDR_W = 3;

    // stream payload widths, whole bytes
    localparam int S_TDATA_W = 8;
    localparam int S_TUSER_W = 8;
    localparam int M_TDATA_W = 40;

    // measurement defaults
    localparam int SAMPLES_PER_BURST_DEF = 8;
    localparam int PERIODS_PER_MEASURE   = 4;
    localparam logic [PERIOD_W-1:0] PERIOD_MAX = 8'hFF;

    // register reset values
    localparam logic [DELAY_W-1:0] DELAY_STEP_RST     = 16'd16;
    localparam logic [DELAY_W-1:0] START_DELAY_RST    = 16'd2000;
    localparam logic [DELAY_W-1:0] MAX_DELAY_RST      = 16'd16000;
    localparam logic [DELAY_W-1:0] MIN_CURRENT_RST    = 16'd10;
    localparam logic [DELAY_W-1:0] TARGET_CURRENT_RST = 16'd500;
    localparam logic [DELAY_W-1:0] HYSTERESIS_RST     = 16'd20;

    // configuration register indexes
    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_DELAY_STEP     = 3'd0,
        REG_START_DELAY    = 3'd1,
        REG_MAX_DELAY      = 3'd2,
        REG_MIN_CURRENT    = 3'd3,
        REG_TARGET_CURRENT = 3'd4,
        REG_HYSTERESIS     = 3'd5
    } cfg_reg_t;

    // event kinds
    typedef enum logic [ACTION_W-1:0] {
        ACT_ZERO_CROSS = 2'd0,
        ACT_TIMER_END  = 2'd1,
        ACT_SAMPLE     = 2'd2
    } action_t;

    // saturating 16-bit add
    function automatic logic [DELAY_W-1:0] sat_add(input logic [DELAY_W-1:0] a,
                                                   input logic [DELAY_W-1:0] b);
        logic [DELAY_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[DELAY_W] ? {DELAY_W{1'b1}} : s[DELAY_W-1:0];
    endfunction

endpackage

[design/dimmer_phase_delay_regulator.sv]
// channel  | ports                         | request
// ---------+-------------------------------+------------------------------------------
// input    | s_tvalid s_tready s_tdata/user| one event: kind and current sample
// result   | m_tvalid m_tready m_tdata     | gate, timer, adc and measurement outputs
// config   | cfg_we cfg_addr cfg_wdata     | register write, no read-back
//
// one event per clock while the output register can take it; its result appears in the output register the next cycle.
// the state update and the result are one pass of logic off the state registers.
// a full output register stalls input only while m_tready is low.
// synchronous active-low reset restores register defaults and clears all state but the output data register.
module dimmer_phase_delay_regulator
    import dpdr_pkg::*;
#(
    parameter int SAMPLES_PER_BURST = SAMPLES_PER_BURST_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // [7:0] sample_value
    input  logic [S_TUSER_W-1:0]  s_tuser,   // [1:0] action, rest zero
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [0] gate_level, [1] timer_start, [17:2] timer_load, [18] adc_request,
    // [34:19] measured_current, [35] measure_done, [39:36] zero
    output logic [M_TDATA_W-1:0]  m_tdata,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [DELAY_W-1:0]    cfg_wdata
);

    localparam int SCNT_W = (SAMPLES_PER_BURST > 1) ? $clog2(SAMPLES_PER_BURST) : 1;

    // configuration registers
    logic [DELAY_W-1:0] delay_step_reg, start_delay_reg, max_delay_reg;
    logic [DELAY_W-1:0] min_current_reg, target_current_reg, hysteresis_reg;

    // regulator state
    logic [DELAY_W-1:0]  gate_delay_reg, gate_delay_next;
    logic                soft_done_reg, soft_done_next;
    logic                fresh_reg, fresh_next;
    logic [DELAY_W-1:0]  current_value_reg, current_value_next;
    logic [DELAY_W-1:0]  current_sum_reg, current_sum_next;
    logic [SCNT_W-1:0]   sample_cnt_reg, sample_cnt_next;
    logic [PERIOD_W-1:0] period_cnt_reg, period_cnt_next;
    logic                gate_on_reg, gate_on_next;

    // output register
    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;

    // per-event logic
    action_t            action;
    logic [SAMPLE_W-1:0] sample;
    logic               accept;
    logic               timer_start, adc_request, measure_done;
    logic [DELAY_W-1:0] timer_load;
    logic [DELAY_W-1:0] zc_delay;
    logic [DELAY_W-1:0] delay_inc;
    logic [DELAY_W:0]   band_lo_sum, band_hi;
    logic [SCNT_W:0]    sample_cnt_inc;

    assign action   = action_t'(s_tuser[ACTION_W-1:0]);
    assign sample   = s_tdata[SAMPLE_W-1:0];
    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    assign delay_inc      = sat_add(gate_delay_reg, delay_step_reg);
    // current below target - hysteresis, written without wrap
    assign band_lo_sum    = {1'b0, current_value_reg} + {1'b0, hysteresis_reg};
    assign band_hi        = {1'b0, target_current_reg} + {1'b0, hysteresis_reg};
    assign sample_cnt_inc = {1'b0, sample_cnt_reg} + (SCNT_W+1)'(1);

    // zero crossing delay update
    always_comb begin
        zc_delay       = gate_delay_reg;
        soft_done_next = soft_done_reg;
        fresh_next     = fresh_reg;
        if (!soft_done_reg) begin
            zc_delay = delay_inc;
            if (delay_inc >= start_delay_reg) begin
                soft_done_next = 1'b1;
            end
        end else if (current_value_reg < min_current_reg) begin
            zc_delay = start_delay_reg;
        end else if (fresh_reg) begin
            fresh_next = 1'b0;
            if (band_lo_sum < {1'b0, target_current_reg}) begin
                zc_delay = (gate_delay_reg < max_delay_reg) ? delay_inc : max_delay_reg;
            end else if ({1'b0, current_value_reg} > band_hi) begin
                zc_delay = (gate_delay_reg > delay_step_reg) ?
                           gate_delay_reg - delay_step_reg : '0;
            end
        end
    end

    // event dispatch
    always_comb begin
        gate_delay_next    = gate_delay_reg;
        current_value_next = current_value_reg;
        current_sum_next   = current_sum_reg;
        sample_cnt_next    = sample_cnt_reg;
        period_cnt_next    = period_cnt_reg;
        gate_on_next       = gate_on_reg;
        timer_start        = 1'b0;
        timer_load         = '0;
        adc_request        = 1'b0;
        measure_done       = 1'b0;
        case (action)
            ACT_ZERO_CROSS: begin
                gate_delay_next = zc_delay;
                if (zc_delay != '0) begin
                    gate_on_next = 1'b1;
                    timer_start  = 1'b1;
                    timer_load   = zc_delay;
                end
            end
            ACT_TIMER_END: begin
                gate_on_next = 1'b0;
                adc_request  = 1'b1;
                if (period_cnt_reg != PERIOD_MAX) begin
                    period_cnt_next = period_cnt_reg + PERIOD_W'(1);
                end
            end
            ACT_SAMPLE: begin
                current_sum_next = sat_add(current_sum_reg, DELAY_W'(sample));
                sample_cnt_next  = sample_cnt_inc[SCNT_W-1:0];
                if (sample_cnt_inc >= (SCNT_W+1)'(SAMPLES_PER_BURST)) begin
                    sample_cnt_next = '0;
                    if (period_cnt_reg >= PERIOD_W'(PERIODS_PER_MEASURE)) begin
                        period_cnt_next    = '0;
                        current_value_next = current_sum_next;
                        current_sum_next   = '0;
                        measure_done       = 1'b1;
                    end
                end else begin
                    adc_request = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delay_step_reg     <= DELAY_STEP_RST;
            start_delay_reg    <= START_DELAY_RST;
            max_delay_reg      <= MAX_DELAY_RST;
            min_current_reg    <= MIN_CURRENT_RST;
            target_current_reg <= TARGET_CURRENT_RST;
            hysteresis_reg     <= HYSTERESIS_RST;
        end else if (cfg_we) begin
            case (cfg_reg_t'(cfg_addr))
                REG_DELAY_STEP:     delay_step_reg     <= cfg_wdata;
                REG_START_DELAY:    start_delay_reg    <= cfg_wdata;
                REG_MAX_DELAY:      max_delay_reg      <= cfg_wdata;
                REG_MIN_CURRENT:    min_current_reg    <= cfg_wdata;
                REG_TARGET_CURRENT: target_current_reg <= cfg_wdata;
                REG_HYSTERESIS:     hysteresis_reg     <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // state update on each accepted event
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gate_delay_reg    <= '0;
            soft_done_reg     <= 1'b0;
            fresh_reg         <= 1'b0;
            current_value_reg <= '0;
            current_sum_reg   <= '0;
            sample_cnt_reg    <= '0;
            period_cnt_reg    <= '0;
            gate_on_reg       <= 1'b0;
        end else if (accept) begin
            gate_delay_reg    <= gate_delay_next;
            current_value_reg <= current_value_next;
            current_sum_reg   <= current_sum_next;
            sample_cnt_reg    <= sample_cnt_next;
            period_cnt_reg    <= period_cnt_next;
            gate_on_reg       <= gate_on_next;
            if (action == ACT_ZERO_CROSS) begin
                soft_done_reg <= soft_done_next;
                fresh_reg     <= fresh_next;
            end else if (measure_done) begin
                fresh_reg     <= 1'b1;
            end
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (s_tready) begin
            m_tvalid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_tdata_reg <= {4'b0, measure_done, current_value_next, adc_request,
                            timer_load, timer_start, gate_on_next};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
